// ----- hdl/url_percent_decoder_defines.svh -----
// Assertion macros shared by the decoder modules.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Check that cons holds whenever ante holds.
`define UPD_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define UPD_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/upd_pkg.sv -----
`default_nettype none

package upd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;
   localparam int GROUP_MAX = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   typedef struct packed {
      logic [GROUP_MAX-1:0][7:0] byte_list;
      logic [1:0]                count;
      logic                      str_end;
   } group_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [4:0] res;
      res = 5'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         res = {1'b1, 4'(ch - 8'h30)};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         res = {1'b1, 4'(ch - 8'h37)};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         res = {1'b1, 4'(ch - 8'h57)};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/upd_req_if.sv -----
`default_nettype none

interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_end;

   modport source (output valid, output out_byte, output run_last, output string_end,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input string_end,
                 output ready);
endinterface

`default_nettype wire

// ----- hdl/url_percent_decoder.sv -----
// channel   | direction | word fields
// ----------+-----------+----------------------------------
// req_word  | in        | in_byte[7:0], is_last
// rsp_word  | out       | out_byte[7:0], run_last, string_end
//
// Accepts one input word per cycle while the 4-group queue has room.
// Emits one output word per cycle while a group is queued and rsp_word.ready is high;
// an input expands to 0..3 output words, which pass through the registered group queue.
// Reset is synchronous; after reset no '%' or digit is held.
// A stalled output fills the queue, then req_word.ready drops.
`default_nettype none

module url_percent_decoder (
   input  logic      clock,
   input  logic      reset,
   upd_req_if.sink   req_word,
   upd_rsp_if.source rsp_word
);
   import upd_pkg::*;

   logic      push;
   logic      pop;
   logic      q_full;
   logic      q_empty;
   group_type push_grp;
   group_type head;

   upd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .q_full   (q_full),
      .push     (push),
      .push_grp (push_grp)
   );

   upd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_grp (push_grp),
      .full     (q_full),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty)
   );

   upd_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .empty    (q_empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

// ----- hdl/upd_front.sv -----
`default_nettype none

module upd_front (
   input  logic              clock,
   input  logic              reset,
   upd_req_if.sink           req_word,
   input  logic              q_full,
   output logic              push,
   output upd_pkg::group_type push_grp
);
   import upd_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_PCT   = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic [4:0] cur_hex;
   logic [4:0] held_hex;
   logic       as_idle;
   logic [1:0] n;
   logic [7:0] slot [4];

   assign req_word.ready = !q_full;
   assign accept = req_word.valid && !q_full;
   assign cur_hex = hex_value(req_word.in_byte);
   assign held_hex = hex_value(held_ff);

   always_comb begin
      phase_in = phase_ff;
      held_in = held_ff;
      as_idle = 1'b0;
      n = 2'd0;
      for (int i = 0; i < 4; i++) begin
         slot[i] = 8'd0;
      end
      case (phase_ff)
         PH_PCT: begin
            if (cur_hex[4]) begin
               held_in = req_word.in_byte;
               phase_in = PH_DIGIT;
            end else begin
               slot[0] = PCT_CHAR;
               n = 2'd1;
               as_idle = 1'b1;
            end
         end
         PH_DIGIT: begin
            if (cur_hex[4]) begin
               slot[0] = {held_hex[3:0], cur_hex[3:0]};
               n = 2'd1;
               phase_in = PH_IDLE;
            end else begin
               slot[0] = PCT_CHAR;
               slot[1] = held_ff;
               n = 2'd2;
               as_idle = 1'b1;
            end
         end
         default: begin
            as_idle = 1'b1;
         end
      endcase
      if (as_idle) begin
         if (req_word.in_byte == PCT_CHAR) begin
            phase_in = PH_PCT;
         end else begin
            slot[n] = req_word.in_byte;
            n = n + 2'd1;
            phase_in = PH_IDLE;
         end
      end
      if (req_word.is_last) begin
         if (phase_in == PH_PCT) begin
            slot[n] = PCT_CHAR;
            n = n + 2'd1;
         end else if (phase_in == PH_DIGIT) begin
            slot[n] = PCT_CHAR;
            slot[n + 2'd1] = held_in;
            n = n + 2'd2;
         end
         phase_in = PH_IDLE;
         held_in = 8'd0;
      end
   end

   always_comb begin
      for (int i = 0; i < GROUP_MAX; i++) begin
         push_grp.byte_list[i] = slot[i];
      end
      push_grp.count = n;
      push_grp.str_end = req_word.is_last;
   end

   assign push = accept && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/upd_queue.sv -----
`default_nettype none
`include "url_percent_decoder_defines.svh"

module upd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  upd_pkg::group_type push_grp,
   output logic              full,
   input  logic              pop,
   output upd_pkg::group_type head,
   output logic              empty
);
   import upd_pkg::*;

   group_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_grp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   `UPD_IMPLY(q_no_overflow, push, !full, "push into full queue")
   `UPD_IMPLY(q_no_underflow, pop, !empty, "pop from empty queue")
   `UPD_IMPLY(q_no_empty_group, push, push_grp.count != 2'd0, "empty group pushed")
   `UPD_NEXT(q_fill, push && !pop && empty, count_ff == QCNT_W'(1), "fill count lost")

endmodule

`default_nettype wire

// ----- hdl/upd_emit.sv -----
`default_nettype none
`include "url_percent_decoder_defines.svh"

module upd_emit (
   input  logic              clock,
   input  logic              reset,
   input  upd_pkg::group_type head,
   input  logic              empty,
   output logic              pop,
   upd_rsp_if.source         rsp_word
);
   import upd_pkg::*;

   logic [1:0] sel_ff, sel_in;
   logic       send;
   logic       end_of_group;

   assign end_of_group = (sel_ff == head.count - 2'd1);
   assign send = !empty && rsp_word.ready;
   assign pop = send && end_of_group;

   assign rsp_word.valid = !empty;
   assign rsp_word.out_byte = head.byte_list[sel_ff];
   assign rsp_word.run_last = end_of_group;
   assign rsp_word.string_end = end_of_group && head.str_end;

   always_comb begin
      sel_in = sel_ff;
      if (pop) begin
         sel_in = 2'd0;
      end else if (send) begin
         sel_in = sel_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 2'd0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   `UPD_IMPLY(e_sel_in_group, !empty, sel_ff < head.count, "byte select past group")
   `UPD_IMPLY(e_sel_idle, empty, sel_ff == 2'd0, "byte select not cleared")

endmodule

`default_nettype wire
